@@ hdl/scfl_pkg.sv @@
package scfl_pkg;

    localparam int PTR_W   = 48;
    localparam int BYTES_W = 32;
    localparam int CLASS_W = 33;
    localparam int TOTB_W  = 29;
    localparam int TOTN_W  = 11;
    localparam int IDX_W   = 11;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_MISS      = 3'd1,
        ST_CACHED    = 3'd2,
        ST_FULL      = 3'd3,
        ST_IGNORED   = 3'd4,
        ST_TOO_LARGE = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        KIND_STACK  = 2'd0,
        KIND_IGNORE = 2'd1,
        KIND_LARGE  = 2'd2
    } kind_t;

    typedef struct packed {
        logic               is_free;
        kind_t              kind;
        logic [PTR_W-1:0]   ptr;
        logic [CLASS_W-1:0] cls;
        logic [IDX_W-1:0]   idx;
    } item_t;

endpackage

@@ hdl/scfl_front.sv @@
module scfl_front #(
    parameter int MAX_REQUEST_BYTES = 262144,
    parameter int POINTER_WIDTH     = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_free,
    input  logic [31:0]           in_bytes,
    input  logic [47:0]           in_ptr,
    output logic                  q_valid,
    input  logic                  q_take,
    output scfl_pkg::item_t       q_item
);
    import scfl_pkg::*;

    localparam logic [PTR_W-1:0] PTR_MASK = (POINTER_WIDTH >= PTR_W) ? {PTR_W{1'b1}} :
        ((PTR_W'(1) << POINTER_WIDTH) - PTR_W'(1));

    item_t              item;
    logic [31:0]        bm1;
    logic [CLASS_W-1:0] rmask;
    logic [31:0]        idx_wide;
    logic [PTR_W-1:0]   ptr_m;

    item_t       q_mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;

    always_comb begin
        bm1   = in_bytes - 32'd1;
        ptr_m = in_ptr & PTR_MASK;
        if (in_bytes <= 32'd256) begin
            rmask    = CLASS_W'(15);
            idx_wide = bm1 >> 4;
        end else if (in_bytes <= 32'd4096) begin
            rmask    = CLASS_W'(127);
            idx_wide = 32'd14 + (bm1 >> 7);
        end else if (in_bytes <= 32'd65536) begin
            rmask    = CLASS_W'(1023);
            idx_wide = 32'd42 + (bm1 >> 10);
        end else begin
            rmask    = CLASS_W'(4095);
            idx_wide = 32'd90 + (bm1 >> 12);
        end
        item.is_free = in_free;
        item.ptr     = ptr_m;
        item.idx     = idx_wide[IDX_W-1:0];
        item.cls     = (in_bytes == 32'd0) ? '0 : (({1'b0, bm1} | rmask) + CLASS_W'(1));
        if (in_bytes == 32'd0 || (in_free && ptr_m == '0)) begin
            item.kind = KIND_IGNORE;
        end else if (in_bytes > 32'(MAX_REQUEST_BYTES)) begin
            item.kind = KIND_LARGE;
        end else begin
            item.kind = KIND_STACK;
        end
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_take;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

@@ hdl/scfl_back.sv @@
module scfl_back #(
    parameter int MAX_REQUEST_BYTES = 262144,
    parameter int SLOTS_PER_CLASS   = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_take,
    input  scfl_pkg::item_t        q_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output scfl_pkg::status_t      out_status,
    output logic [47:0]            out_ptr,
    output logic [32:0]            out_cls,
    output logic [28:0]            out_totb,
    output logic [10:0]            out_totn
);
    import scfl_pkg::*;

    localparam int NUM_CLASSES = 106 + (MAX_REQUEST_BYTES - 65536 + 4095) / 4096;
    localparam int DEPTH       = NUM_CLASSES * SLOTS_PER_CLASS;
    localparam int CIW         = $clog2(NUM_CLASSES);
    localparam int AW          = $clog2(DEPTH);
    localparam int LW          = $clog2(SLOTS_PER_CLASS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LVL  = 3'b010,
        S_STK  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    item_t               item_reg;
    logic [LW-1:0]       fill_mem [NUM_CLASSES];
    logic [LW-1:0]       fill_rd_reg;
    logic [NUM_CLASSES-1:0] fvalid_reg;
    logic                fvalid_rd_reg;
    logic [PTR_W-1:0]    stk_mem [DEPTH];
    logic [PTR_W-1:0]    stk_rd_reg;

    logic [TOTB_W-1:0]   totb_reg, totb_next;
    logic [TOTN_W-1:0]   totn_reg, totn_next;
    logic                ov_reg, ov_next;
    status_t             ost_reg, ost_next;
    logic [PTR_W-1:0]    optr_reg, optr_next;
    logic [CLASS_W-1:0]  ocls_reg, ocls_next;
    logic                ld_out;

    logic [CIW-1:0]      ci;
    logic [LW-1:0]       lvl;
    logic [AW-1:0]       base;
    logic                fill_we, stk_we, stk_re;
    logic [LW-1:0]       fill_wd;
    logic [AW-1:0]       stk_addr;

    assign ci   = item_reg.idx[CIW-1:0];
    assign lvl  = fvalid_rd_reg ? fill_rd_reg : '0;
    assign base = AW'(ci) * AW'(SLOTS_PER_CLASS);

    assign q_take = (state_reg == S_IDLE) && q_valid && !ov_reg;

    always_comb begin
        state_next = state_reg;
        totb_next  = totb_reg;
        totn_next  = totn_reg;
        ov_next    = ov_reg && !out_ready;
        ost_next   = ost_reg;
        optr_next  = optr_reg;
        ocls_next  = ocls_reg;
        ld_out     = 1'b0;
        fill_we    = 1'b0;
        fill_wd    = lvl;
        stk_we     = 1'b0;
        stk_re     = 1'b0;
        stk_addr   = base + AW'(lvl);
        case (state_reg)
            S_IDLE: begin
                if (q_take) begin
                    state_next = S_LVL;
                end
            end
            S_LVL: begin
                ld_out     = 1'b1;
                state_next = S_IDLE;
                optr_next  = '0;
                ocls_next  = item_reg.cls;
                if (item_reg.kind == KIND_IGNORE) begin
                    ost_next = ST_IGNORED;
                end else if (item_reg.kind == KIND_LARGE) begin
                    ost_next  = ST_TOO_LARGE;
                    optr_next = item_reg.is_free ? item_reg.ptr : '0;
                end else if (!item_reg.is_free) begin
                    if (lvl != '0) begin
                        ld_out     = 1'b0;
                        state_next = S_STK;
                        stk_re     = 1'b1;
                        stk_addr   = base + AW'(lvl - LW'(1));
                        fill_we    = 1'b1;
                        fill_wd    = lvl - LW'(1);
                    end else begin
                        ost_next = ST_MISS;
                    end
                end else if (lvl >= LW'(SLOTS_PER_CLASS)) begin
                    ost_next  = ST_FULL;
                    optr_next = item_reg.ptr;
                end else begin
                    ost_next  = ST_CACHED;
                    stk_we    = 1'b1;
                    fill_we   = 1'b1;
                    fill_wd   = lvl + LW'(1);
                    totb_next = totb_reg + item_reg.cls[TOTB_W-1:0];
                    totn_next = totn_reg + TOTN_W'(1);
                end
                if (ld_out) begin
                    ov_next = 1'b1;
                end
            end
            S_STK: begin
                state_next = S_IDLE;
                ld_out     = 1'b1;
                ov_next    = 1'b1;
                ost_next   = ST_HIT;
                optr_next  = stk_rd_reg;
                ocls_next  = item_reg.cls;
                totb_next  = totb_reg - item_reg.cls[TOTB_W-1:0];
                totn_next  = totn_reg - TOTN_W'(1);
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            fvalid_reg <= '0;
            totb_reg   <= '0;
            totn_reg   <= '0;
            ov_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            totb_reg  <= totb_next;
            totn_reg  <= totn_next;
            ov_reg    <= ov_next;
            if (fill_we) begin
                fvalid_reg[ci] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_take) begin
            item_reg      <= q_item;
            fill_rd_reg   <= fill_mem[q_item.idx[CIW-1:0]];
            fvalid_rd_reg <= fvalid_reg[q_item.idx[CIW-1:0]];
        end
        if (fill_we) begin
            fill_mem[ci] <= fill_wd;
        end
        if (stk_we) begin
            stk_mem[stk_addr] <= item_reg.ptr;
        end
        if (stk_re) begin
            stk_rd_reg <= stk_mem[stk_addr];
        end
        if (ld_out) begin
            ost_reg  <= ost_next;
            optr_reg <= optr_next;
            ocls_reg <= ocls_next;
        end
    end

    assign out_valid  = ov_reg;
    assign out_status = ost_reg;
    assign out_ptr    = optr_reg;
    assign out_cls    = ocls_reg;
    assign out_totb   = totb_reg;
    assign out_totn   = totn_reg;

`ifndef SYNTHESIS
    a_lvl_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LVL && item_reg.kind == KIND_STACK) |->
            (lvl <= LW'(SLOTS_PER_CLASS)))
        else $error("fill level above slot count");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        q_take |-> (state_reg == S_IDLE && !ov_reg))
        else $error("item taken while busy");
    a_hit_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_STK) |-> $past(state_reg == S_LVL))
        else $error("stack read without level lookup");
    a_out_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ov_reg) |-> $past(state_reg != S_IDLE))
        else $error("result without work");
`endif

endmodule

@@ hdl/size_class_free_list_cache.sv @@
// channel   dir  tdata (low bit up)                          tuser
// s_axis    in   request_bytes[31:0], block_pointer[79:32]   opcode
// m_axis    out  result_pointer[47:0], class_bytes[80:48],   status
//                total_cached_bytes[109:81],
//                total_cached_blocks[120:110]
// An item passes a level lookup, then on an allocate hit also a stack read.
// The stack RAM and level RAM are read through registered ports; one item is worked at a time.
// A two-word queue keeps taking input until it is full while the back end or the result stalls.
// aresetn clears the queue, levels and totals at once; no clearing pass.
module size_class_free_list_cache #(
    parameter int MAX_REQUEST_BYTES = 262144,
    parameter int SLOTS_PER_CLASS   = 8,
    parameter int POINTER_WIDTH     = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [79:0]  s_axis_tdata,  // request_bytes, block_pointer
    input  logic         s_axis_tuser,  // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // result_pointer, class_bytes, totals bytes, blocks
    output logic [2:0]   m_axis_tuser   // status
);
    import scfl_pkg::*;

    logic       q_valid, q_take;
    item_t      q_item;
    status_t    st;
    logic [47:0] optr;
    logic [32:0] ocls;
    logic [28:0] otb;
    logic [10:0] otn;

    scfl_front #(
        .MAX_REQUEST_BYTES(MAX_REQUEST_BYTES),
        .POINTER_WIDTH(POINTER_WIDTH)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .in_free(s_axis_tuser),
        .in_bytes(s_axis_tdata[31:0]),
        .in_ptr(s_axis_tdata[79:32]),
        .q_valid(q_valid),
        .q_take(q_take),
        .q_item(q_item)
    );

    scfl_back #(
        .MAX_REQUEST_BYTES(MAX_REQUEST_BYTES),
        .SLOTS_PER_CLASS(SLOTS_PER_CLASS)
    ) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .q_valid(q_valid),
        .q_take(q_take),
        .q_item(q_item),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_status(st),
        .out_ptr(optr),
        .out_cls(ocls),
        .out_totb(otb),
        .out_totn(otn)
    );

    assign m_axis_tuser = st;
    assign m_axis_tdata = {7'd0, otn, otb, ocls, optr};

endmodule

@@ sim/tb.sv @@
module tb;
    import scfl_pkg::*;

    localparam int MAX_REQ = 262144;
    localparam int SLOTS   = 8;
    localparam int NCLS    = 106 + (MAX_REQ - 65536 + 4095) / 4096;
    localparam int LIMIT   = 400000;

    typedef struct packed {
        logic        op;
        logic [31:0] nbytes;
        logic [47:0] ptr;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [47:0] rptr;
        logic [32:0] cls;
        logic [28:0] tot_bytes;
        logic [10:0] tot_blocks;
    } resp_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    size_class_free_list_cache u_top (.*);

    always #5 aclk = ~aclk;

    req_t   pending_reqs[$];
    resp_t  expected_resps[$];
    logic [47:0] stack_mem[NCLS][SLOTS];
    int     fill_lvl[NCLS];
    logic [28:0] cached_bytes;
    logic [10:0] cached_blocks;
    int     errors = 0;
    int     cycles = 0;
    bit     calm = 1'b0;
    bit     driving = 1'b0;
    int     s_gap = 0;
    int     m_gap = 0;

    function automatic logic [32:0] round_class(logic [31:0] b);
        logic [32:0] v;
        logic [32:0] st;
        v = {1'b0, b};
        st = (b <= 256) ? 16 : (b <= 4096) ? 128 : (b <= 65536) ? 1024 : 4096;
        return ((v + st - 1) / st) * st;
    endfunction

    function automatic int class_slot(logic [32:0] c);
        int i;
        if (c <= 256) i = c / 16 - 1;
        else if (c <= 4096) i = 16 + (c - 384) / 128;
        else if (c <= 65536) i = 46 + (c - 5120) / 1024;
        else i = 106 + (c - 69632) / 4096;
        if (i >= NCLS) i = NCLS - 1;
        return i;
    endfunction

    function automatic resp_t predict_cache(req_t r);
        resp_t o;
        int ci;
        o.cls = round_class(r.nbytes);
        o.rptr = '0;
        if (r.nbytes == 0 || (r.op && r.ptr == 0)) begin
            o.status = ST_IGNORED;
        end else if (r.nbytes > MAX_REQ) begin
            o.status = ST_TOO_LARGE;
            if (r.op) o.rptr = r.ptr;
        end else begin
            ci = class_slot(o.cls);
            if (!r.op) begin
                if (fill_lvl[ci] > 0) begin
                    fill_lvl[ci]--;
                    o.rptr = stack_mem[ci][fill_lvl[ci]];
                    cached_bytes = cached_bytes - o.cls[28:0];
                    cached_blocks = cached_blocks - 1;
                    o.status = ST_HIT;
                end else begin
                    o.status = ST_MISS;
                end
            end else if (fill_lvl[ci] >= SLOTS) begin
                o.status = ST_FULL;
                o.rptr = r.ptr;
            end else begin
                stack_mem[ci][fill_lvl[ci]] = r.ptr;
                fill_lvl[ci]++;
                cached_bytes = cached_bytes + o.cls[28:0];
                cached_blocks = cached_blocks + 1;
                o.status = ST_CACHED;
            end
        end
        o.tot_bytes = cached_bytes;
        o.tot_blocks = cached_blocks;
        return o;
    endfunction

    function automatic logic [47:0] rand_ptr();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(1, 48);
            3, 4:    return $urandom_range(1, 4096);
            5:       return $urandom_range(4097, 65536);
            6:       return $urandom_range(65537, MAX_REQ);
            7:       return MAX_REQ + $urandom_range(1, 1000);
            8:       return $urandom();
            default: return $urandom_range(0, 2);
        endcase
    endfunction

    task automatic push_req(logic op, logic [31:0] n, logic [47:0] p);
        req_t r;
        r.op = op;
        r.nbytes = n;
        r.ptr = p;
        pending_reqs = {pending_reqs, r};
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_resps = {expected_resps,
                                  predict_cache({s_axis_tuser, s_axis_tdata[31:0],
                                                 s_axis_tdata[79:32]})};
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (driving && pending_reqs.size() > 0) begin
                    req_t r;
                    r = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= r.op;
                    s_axis_tdata <= {r.ptr, r.nbytes};
                    if (!calm && $urandom_range(0, 5) == 0) s_gap <= $urandom_range(1, 8);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                resp_t e;
                if (expected_resps.size() == 0) begin
                    $error("unexpected word: status %0d", m_axis_tuser);
                    errors++;
                end else begin
                    e = expected_resps.pop_front();
                    if (m_axis_tuser !== e.status) begin
                        $error("status exp %0d got %0d", e.status, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata[47:0] !== e.rptr) begin
                        $error("result_pointer exp %h got %h", e.rptr, m_axis_tdata[47:0]);
                        errors++;
                    end
                    if (m_axis_tdata[80:48] !== e.cls) begin
                        $error("class_bytes exp %0d got %0d", e.cls, m_axis_tdata[80:48]);
                        errors++;
                    end
                    if (m_axis_tdata[109:81] !== e.tot_bytes) begin
                        $error("total_cached_bytes exp %0d got %0d", e.tot_bytes,
                               m_axis_tdata[109:81]);
                        errors++;
                    end
                    if (m_axis_tdata[120:110] !== e.tot_blocks) begin
                        $error("total_cached_blocks exp %0d got %0d", e.tot_blocks,
                               m_axis_tdata[120:110]);
                        errors++;
                    end
                end
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) m_gap <= $urandom_range(1, 8);
            end
        end
        if (cycles >= LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int k;
        logic [31:0] sz;
        cached_bytes = '0;
        cached_blocks = '0;
        foreach (fill_lvl[i]) fill_lvl[i] = 0;
        push_req(1'b0, 32'd0, 48'd0);
        push_req(1'b1, 32'd64, 48'd0);
        push_req(1'b1, 32'd0, 48'hFFFF_FFFF_FFFF);
        push_req(1'b0, 32'hFFFF_FFFF, 48'd0);
        push_req(1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        push_req(1'b1, MAX_REQ + 1, 48'h1234);
        push_req(1'b0, 32'd1, 48'd0);
        for (k = 0; k < 9; k++) push_req(1'b1, 32'd17, 48'hA000 + k);
        for (k = 0; k < 3; k++) push_req(1'b0, 32'd32, 48'd0);
        push_req(1'b1, 32'd4097, 48'hFFFF_FFFF_FFFF);
        push_req(1'b1, MAX_REQ, 48'd1);
        push_req(1'b0, MAX_REQ, 48'd0);
        push_req(1'b0, 32'd4097, 48'hAAAA_5555_AAAA);
        for (k = 0; k < 500; k++) begin
            sz = rand_size();
            if (k % 10 == 0) push_req($urandom_range(0, 1), sz, 48'd0);
            else push_req($urandom_range(0, 1), sz, rand_ptr());
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        driving <= 1'b1;
        while (pending_reqs.size() > 150) @(posedge aclk);
        calm <= 1'b1;
        while (pending_reqs.size() > 0 || s_axis_tvalid) @(posedge aclk);
        while (expected_resps.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
